[hw/rtl/phj_pkg.sv]
// shared constants, types and the output clamp function for the pinhole projection block
// no dependencies
`default_nettype none
package phj_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REG_W = 28;
   localparam int PT_W = 32;
   localparam int PX_W = REG_W + PT_W;
   localparam int MAG_W = 63;
   localparam int DIV_W = 31;
   localparam int MUL_CHUNK = 16;
   localparam int IDX_W = 2;

   localparam logic [IDX_W-1:0] REG_FOCAL_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_FOCAL_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd2;
   localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd3;

   localparam logic [REG_W-1:0] FOCAL_X_RST = 28'd32768000;
   localparam logic [REG_W-1:0] FOCAL_Y_RST = 28'd32768000;
   localparam logic [REG_W-1:0] CENTER_X_RST = 28'd20971520;
   localparam logic [REG_W-1:0] CENTER_Y_RST = 28'd15728640;

   localparam logic [MAG_W-1:0] MAG_CAP = 63'h4000_0000_0000_0000;

   typedef struct packed {
      logic [PT_W-1:0] val;
      logic            sat;
   } out_type;

   // signed magnitude plus offset, clamped to the signed 32-bit range
   function automatic out_type to_out(input logic neg, input logic [MAG_W-1:0] mag,
                                      input logic [REG_W-1:0] off);
      logic signed [64:0] v;
      out_type            o;
      v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      v = v + $signed({37'd0, off});
      o.sat = 1'b0;
      if (v > 65'sd2147483647) begin
         o.val = 32'h7fff_ffff;
         o.sat = 1'b1;
      end else if (v < -65'sd2147483648) begin
         o.val = 32'h8000_0000;
         o.sat = 1'b1;
      end else begin
         o.val = v[PT_W-1:0];
      end
      return o;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/phj_pipe.sv]
// delay line with valid bits for sideband data
// uses no package
`default_nettype none
module phj_pipe #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         vld_i,
   input  wire logic [W-1:0] dat_i,
   output logic              vld_o,
   output logic [W-1:0]      dat_o
);
   logic [D-1:0] vld_ff;
   logic [W-1:0] dat_ff [D];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         for (int k = D - 1; k > 0; k--) vld_ff[k] <= vld_ff[k-1];
         vld_ff[0] <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = D - 1; k > 0; k--) dat_ff[k] <= dat_ff[k-1];
         dat_ff[0] <= dat_i;
      end
   end

   assign vld_o = vld_ff[D-1];
   assign dat_o = dat_ff[D-1];
endmodule
`default_nettype wire

[hw/rtl/phj_div_cell.sv]
// one restoring division cell: one quotient bit per cycle while en is high
// uses no package
`default_nettype none
module phj_div_cell #(
   parameter int DW = 31,
   parameter int QW = 49
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic          bit_i,
   input  wire logic [DW-1:0] rem_i,
   input  wire logic [DW-1:0] d_i,
   input  wire logic [QW-1:0] q_i,
   output logic [DW-1:0]      rem_o,
   output logic [DW-1:0]      d_o,
   output logic [QW-1:0]      q_o
);
   logic [DW:0]   t;
   logic          ge;
   logic [DW:0]   diff;
   logic [DW-1:0] rem_ff, d_ff;
   logic [QW-1:0] q_ff;

   assign t = {rem_i, bit_i};
   assign ge = t >= {1'b0, d_i};
   assign diff = t - {1'b0, d_i};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= ge ? diff[DW-1:0] : t[DW-1:0];
         d_ff <= d_i;
         q_ff <= {q_i[QW-2:0], ge};
      end
   end

   assign rem_o = rem_ff;
   assign d_o = d_ff;
   assign q_o = q_ff;
endmodule
`default_nettype wire

[hw/rtl/phj_recip.sv]
// chain of division cells forming floor(2^(QW-1) / d)
// depends on phj_div_cell
`default_nettype none
module phj_recip #(
   parameter int DW = 31,
   parameter int QW = 49
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] d,
   output logic [QW-1:0]      r
);
   logic [DW-1:0] rem_c [QW+1];
   logic [DW-1:0] d_c [QW+1];
   logic [QW-1:0] q_c [QW+1];

   assign rem_c[0] = '0;
   assign d_c[0] = d;
   assign q_c[0] = '0;

   for (genvar k = 0; k < QW; k++) begin : g_cell
      phj_div_cell #(.DW(DW), .QW(QW)) u_cell (
         .clock(clock), .en(en), .bit_i(k == 0),
         .rem_i(rem_c[k]), .d_i(d_c[k]), .q_i(q_c[k]),
         .rem_o(rem_c[k+1]), .d_o(d_c[k+1]), .q_o(q_c[k+1])
      );
   end

   assign r = q_c[QW];
endmodule
`default_nettype wire

[hw/rtl/phj_mul.sv]
// pipelined multiplier, one 16-bit slice of b per stage
// depends on phj_pkg
`default_nettype none
module phj_mul #(
   parameter int AW = 60,
   parameter int BW = 49
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [AW-1:0] a,
   input  wire logic [BW-1:0] b,
   output logic [AW+BW-1:0]   p
);
   localparam int CH = phj_pkg::MUL_CHUNK;
   localparam int NC = (BW + CH - 1) / CH;
   localparam int BP = NC * CH;
   localparam int PW = AW + BP;

   logic [AW-1:0] a_ff [NC];
   logic [BP-1:0] b_ff [NC];
   logic [PW-1:0] acc_ff [NC];
   logic [BP-1:0] b_pad;

   assign b_pad = BP'(b);

   for (genvar k = 0; k < NC; k++) begin : g_stage
      logic [AW-1:0] a_src;
      logic [BP-1:0] b_src;
      logic [PW-1:0] acc_src;
      logic [PW-1:0] part;
      if (k == 0) begin : g_first
         assign a_src = a;
         assign b_src = b_pad;
         assign acc_src = '0;
      end else begin : g_next
         assign a_src = a_ff[k-1];
         assign b_src = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end
      assign part = (PW'(a_src) * PW'(b_src[CH*k +: CH])) << (CH * k);
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k] <= a_src;
            b_ff[k] <= b_src;
            acc_ff[k] <= acc_src + part;
         end
      end
   end

   assign p = acc_ff[NC-1][AW+BW-1:0];
endmodule
`default_nettype wire

[hw/rtl/pinhole_project_with_jacobian.sv]
// top level: pinhole projection of one camera-frame point with its jacobian entries
// depends on phj_pkg, phj_pipe, phj_recip, phj_mul
//
// usage
//  - req channel carries one point per item (x, y, z, signed fixed point)
//  - rsp channel returns one item per point: u, v, fx/z, -fx*x/z^2, fy/z, -fy*y/z^2
//    plus the depth_invalid and saturated flags in rsp_tuser
//  - intrinsics are to be written on the csr port only while the block is idle; the block does not enforce this
//  - throughput: one item per cycle while no stalled receiver holds the pipeline
//  - path: front register, the reciprocal cell chain (one quotient bit per cell), the
//    first sliced multiplier pipeline, the rounding register, the second sliced
//    multiplier pipeline and the output register
//  - the reciprocal of z is formed once and shared by all six results
//  - reset clears all valid bits and loads the default intrinsics
//  - when the receiver stalls, the result waits in the output register; the pipeline
//    keeps moving and accepting items until a finished item reaches its last stage
`default_nettype none
module pinhole_project_with_jacobian #(
   parameter int FRAC_BITS = phj_pkg::FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // point_x [31:0], point_y [63:32], point_z [95:64]
   input  wire logic [95:0]               req_tdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // pixel_u, pixel_v, jac_u_by_x, jac_u_by_z, jac_v_by_y, jac_v_by_z, 32 bits each
   output logic [191:0]                   rsp_tdata,
   // depth_invalid [0], saturated [1]
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_wen,
   input  wire logic [phj_pkg::IDX_W-1:0] csr_index,
   input  wire logic [phj_pkg::REG_W-1:0] csr_wdata
);
   localparam int RW = FRAC_BITS + 33;            // reciprocal width
   localparam int ML = (RW + phj_pkg::MUL_CHUNK - 1) / phj_pkg::MUL_CHUNK;
   localparam int MW = phj_pkg::MAG_W;
   localparam int PXW = phj_pkg::PX_W;
   localparam int RGW = phj_pkg::REG_W;
   localparam int RNDW = MW + RW + 1;

   typedef struct packed {
      logic           invalid;
      logic           nx;
      logic           ny;
      logic [PXW-1:0] px;
      logic [PXW-1:0] py;
   } front_type;

   typedef struct packed {
      front_type     f;
      logic [RW-1:0] r;
   } mid_type;

   typedef struct packed {
      logic          invalid;
      logic          nx;
      logic          ny;
      logic [MW-1:0] tx;
      logic [MW-1:0] ty;
      logic [MW-1:0] jx;
      logic [MW-1:0] jy;
   } back_type;

   // round half up by 2^s and cap the magnitude at 2^62
   function automatic logic [MW-1:0] rnd_cap(input logic [RNDW-1:0] p, input int s);
      logic [RNDW-1:0] t;
      t = (p + (RNDW'(1) << (s - 1))) >> s;
      if (t > RNDW'(phj_pkg::MAG_CAP)) return phj_pkg::MAG_CAP;
      return t[MW-1:0];
   endfunction

   // configuration registers
   logic [RGW-1:0] fx_ff, fy_ff, cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= phj_pkg::FOCAL_X_RST;
         fy_ff <= phj_pkg::FOCAL_Y_RST;
         cx_ff <= phj_pkg::CENTER_X_RST;
         cy_ff <= phj_pkg::CENTER_Y_RST;
      end else if (csr_wen) begin
         case (csr_index)
            phj_pkg::REG_FOCAL_X:  fx_ff <= csr_wdata;
            phj_pkg::REG_FOCAL_Y:  fy_ff <= csr_wdata;
            phj_pkg::REG_CENTER_X: cx_ff <= csr_wdata;
            phj_pkg::REG_CENTER_Y: cy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: hold only when a finished item cannot enter the output register
   logic en, last_vld, rsp_valid_ff;
   assign en = !last_vld || !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // front stage: magnitudes, signs, depth check, focal times coordinate
   logic [31:0] px_raw, py_raw, pz_raw, mx, my;
   logic        nx, ny, zbad;
   front_type   front_in, front_ff;
   logic        vld0_ff;
   logic [phj_pkg::DIV_W-1:0] dz_ff;

   assign px_raw = req_tdata[31:0];
   assign py_raw = req_tdata[63:32];
   assign pz_raw = req_tdata[95:64];
   assign nx = px_raw[31];
   assign ny = py_raw[31];
   assign mx = nx ? (~px_raw + 32'd1) : px_raw;
   assign my = ny ? (~py_raw + 32'd1) : py_raw;
   assign zbad = pz_raw[31] || (pz_raw == 32'd0);

   always_comb begin
      front_in.invalid = zbad;
      front_in.nx = nx;
      front_in.ny = ny;
      front_in.px = PXW'(fx_ff) * PXW'(mx);
      front_in.py = PXW'(fy_ff) * PXW'(my);
   end

   always_ff @(posedge clock) begin
      if (reset) vld0_ff <= 1'b0;
      else if (en) vld0_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
         dz_ff <= pz_raw[phj_pkg::DIV_W-1:0];
      end
   end

   // reciprocal chain, r = 2^(FRAC_BITS+32) / z
   logic [RW-1:0] recip;
   front_type     front_d;
   logic          vld_d;

   phj_recip #(.DW(phj_pkg::DIV_W), .QW(RW)) u_recip (
      .clock(clock), .en(en), .d(dz_ff), .r(recip)
   );

   phj_pipe #(.W($bits(front_type)), .D(RW)) u_pipe_div (
      .clock(clock), .reset(reset), .en(en), .vld_i(vld0_ff), .dat_i(front_ff),
      .vld_o(vld_d), .dat_o(front_d)
   );

   // first products against the reciprocal
   logic [PXW+RW-1:0] prod_tx, prod_ty;
   logic [RGW+RW-1:0] prod_jx, prod_jy;
   mid_type           mid_in, mid_d;
   logic              vld_m;

   phj_mul #(.AW(PXW), .BW(RW)) u_mul_tx (
      .clock(clock), .en(en), .a(front_d.px), .b(recip), .p(prod_tx));
   phj_mul #(.AW(PXW), .BW(RW)) u_mul_ty (
      .clock(clock), .en(en), .a(front_d.py), .b(recip), .p(prod_ty));
   phj_mul #(.AW(RGW), .BW(RW)) u_mul_jx (
      .clock(clock), .en(en), .a(fx_ff), .b(recip), .p(prod_jx));
   phj_mul #(.AW(RGW), .BW(RW)) u_mul_jy (
      .clock(clock), .en(en), .a(fy_ff), .b(recip), .p(prod_jy));

   assign mid_in.f = front_d;
   assign mid_in.r = recip;

   phj_pipe #(.W($bits(mid_type)), .D(ML)) u_pipe_m1 (
      .clock(clock), .reset(reset), .en(en), .vld_i(vld_d), .dat_i(mid_in),
      .vld_o(vld_m), .dat_o(mid_d)
   );

   // rounding stage
   back_type      back_ff;
   logic [RW-1:0] r2_ff;
   logic          vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (en) vld1_ff <= vld_m;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         back_ff.invalid <= mid_d.f.invalid;
         back_ff.nx <= mid_d.f.nx;
         back_ff.ny <= mid_d.f.ny;
         back_ff.tx <= rnd_cap(RNDW'(prod_tx), FRAC_BITS + 32);
         back_ff.ty <= rnd_cap(RNDW'(prod_ty), FRAC_BITS + 32);
         back_ff.jx <= rnd_cap(RNDW'(prod_jx), 32);
         back_ff.jy <= rnd_cap(RNDW'(prod_jy), 32);
         r2_ff <= mid_d.r;
      end
   end

   // second products: depth derivatives from the rounded projection terms
   logic [MW+RW-1:0] prod_uz, prod_vz;
   back_type         back_d;

   phj_mul #(.AW(MW), .BW(RW)) u_mul_uz (
      .clock(clock), .en(en), .a(back_ff.tx), .b(r2_ff), .p(prod_uz));
   phj_mul #(.AW(MW), .BW(RW)) u_mul_vz (
      .clock(clock), .en(en), .a(back_ff.ty), .b(r2_ff), .p(prod_vz));

   phj_pipe #(.W($bits(back_type)), .D(ML)) u_pipe_m2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(vld1_ff), .dat_i(back_ff),
      .vld_o(last_vld), .dat_o(back_d)
   );

   // offsets, clamping and flags
   phj_pkg::out_type o_u, o_v, o_ux, o_uz, o_vy, o_vz;
   logic [191:0]     data_in;
   logic [1:0]       user_in;

   always_comb begin
      o_u = phj_pkg::to_out(back_d.nx, back_d.tx, cx_ff);
      o_v = phj_pkg::to_out(back_d.ny, back_d.ty, cy_ff);
      o_ux = phj_pkg::to_out(1'b0, back_d.jx, '0);
      o_uz = phj_pkg::to_out(!back_d.nx, rnd_cap(RNDW'(prod_uz), 32), '0);
      o_vy = phj_pkg::to_out(1'b0, back_d.jy, '0);
      o_vz = phj_pkg::to_out(!back_d.ny, rnd_cap(RNDW'(prod_vz), 32), '0);
      if (back_d.invalid) begin
         data_in = '0;
         user_in = 2'b01;
      end else begin
         data_in = {o_vz.val, o_vy.val, o_uz.val, o_ux.val, o_v.val, o_u.val};
         user_in = {o_u.sat | o_v.sat | o_ux.sat | o_uz.sat | o_vy.sat | o_vz.sat, 1'b0};
      end
   end

   // output register
   logic [191:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && last_vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && last_vld) begin
         rsp_data_ff <= data_in;
         rsp_user_ff <= user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
endmodule
`default_nettype wire

[hw/rtl/phj_checker.sv]
// port-level checks for the pinhole projection block, bound to its top level
// depends on pinhole_project_with_jacobian
`default_nettype none
module phj_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic [191:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready
);
   // a waiting result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   // bad depth gives an all-zero item without the clip flag
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 192'd0) && !rsp_tuser[1])
      else $error("invalid depth item not cleared");

   // fx/z can never come out negative
   a_jux_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tdata[95])
      else $error("negative fx/z");

   // no result right after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind pinhole_project_with_jacobian phj_checker u_phj_checker (
   .clock(clock), .reset(reset), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
);
`default_nettype wire

[sim/phj_projection_checker.sv]
// checker for the pinhole projection block: follows the req, rsp and csr ports,
// predicts each projection and compares it with what comes out; depends on phj_pkg
`timescale 1ns / 100ps
module phj_projection_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [95:0]               req_tdata,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [191:0]              rsp_tdata,
   input  wire logic [1:0]                rsp_tuser,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_wen,
   input  wire logic [phj_pkg::IDX_W-1:0] csr_index,
   input  wire logic [phj_pkg::REG_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             projections_pending
);
   localparam int FB = phj_pkg::FRAC_BITS_DEF;
   localparam logic [127:0] CAP = 128'd1 << 62;

   typedef struct packed {
      logic [191:0] data;
      logic [1:0]   user;
   } projection_type;

   logic [phj_pkg::REG_W-1:0] focal_x, focal_y, center_x, center_y;
   projection_type            projections_due[$];

   assign projections_pending = projections_due.size();

   function automatic logic [127:0] round_product(input logic [127:0] a, input logic [127:0] b,
                                                  input int s);
      logic [127:0] p;
      p = (a * b + (128'd1 << (s - 1))) >> s;
      return (p > CAP) ? CAP : p;
   endfunction

   // returns {clipped, value}
   function automatic logic [32:0] clamp_field(input logic neg, input logic [127:0] mag,
                                               input logic [phj_pkg::REG_W-1:0] off);
      logic signed [71:0] v;
      v = $signed({8'd0, mag[63:0]});
      if (neg) v = -v;
      v = v + $signed({44'd0, off});
      if (v > 72'sd2147483647) return {1'b1, 32'h7fff_ffff};
      if (v < -72'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   function automatic logic [127:0] abs_coord(input logic [31:0] c);
      return c[31] ? ((128'd1 << 32) - {96'd0, c}) : {96'd0, c};
   endfunction

   function automatic projection_type project_point(input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] z);
      projection_type p;
      logic [127:0]   recip, tx, ty;
      logic [32:0]    u, v, jux, juz, jvy, jvz;
      p = '0;
      // no projection behind or on the camera plane
      if (z[31] || z == 32'd0) begin
         p.user = 2'b01;
         return p;
      end
      recip = (128'd1 << (FB + 32)) / {96'd0, z};
      tx = round_product({100'd0, focal_x} * abs_coord(x), recip, FB + 32);
      ty = round_product({100'd0, focal_y} * abs_coord(y), recip, FB + 32);
      u   = clamp_field(x[31], tx, center_x);
      v   = clamp_field(y[31], ty, center_y);
      jux = clamp_field(1'b0, round_product({100'd0, focal_x}, recip, 32), '0);
      juz = clamp_field(!x[31], round_product(tx, recip, 32), '0);
      jvy = clamp_field(1'b0, round_product({100'd0, focal_y}, recip, 32), '0);
      jvz = clamp_field(!y[31], round_product(ty, recip, 32), '0);
      p.data = {jvz[31:0], jvy[31:0], juz[31:0], jux[31:0], v[31:0], u[31:0]};
      p.user = {u[32] | v[32] | jux[32] | juz[32] | jvy[32] | jvz[32], 1'b0};
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         focal_x  <= phj_pkg::FOCAL_X_RST;
         focal_y  <= phj_pkg::FOCAL_Y_RST;
         center_x <= phj_pkg::CENTER_X_RST;
         center_y <= phj_pkg::CENTER_Y_RST;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               phj_pkg::REG_FOCAL_X:  focal_x  <= csr_wdata;
               phj_pkg::REG_FOCAL_Y:  focal_y  <= csr_wdata;
               phj_pkg::REG_CENTER_X: center_x <= csr_wdata;
               phj_pkg::REG_CENTER_Y: center_y <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            projections_due.push_back(project_point(req_tdata[31:0], req_tdata[63:32],
                                                    req_tdata[95:64]));
         if (rsp_tvalid && rsp_tready) begin
            if (projections_due.size() == 0) begin
               report_mismatch("item with none due", rsp_tdata[31:0], '0);
            end else begin
               projection_type want;
               want = projections_due.pop_front();
               for (int f = 0; f < 6; f++)
                  if (rsp_tdata[32*f +: 32] !== want.data[32*f +: 32])
                     report_mismatch($sformatf("field %0d", f), rsp_tdata[32*f +: 32],
                                     want.data[32*f +: 32]);
               if (rsp_tuser[0] !== want.user[0])
                  report_mismatch("depth_invalid", 32'(rsp_tuser[0]), 32'(want.user[0]));
               if (rsp_tuser[1] !== want.user[1])
                  report_mismatch("saturated", 32'(rsp_tuser[1]), 32'(want.user[1]));
            end
         end
      end
   end
endmodule

[sim/pinhole_project_with_jacobian_test.sv]
// testbench top for pinhole_project_with_jacobian: drives points and csr writes,
// gives the verdict; depends on phj_pkg, phj_projection_checker and pinhole_project_with_jacobian
`timescale 1ns / 100ps
module pinhole_project_with_jacobian_test;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 80;       // extra wait after the last projection has come back
   localparam int RGW = phj_pkg::REG_W;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic [95:0]                   req_tdata = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [191:0]                  rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          csr_wen = 1'b0;
   logic [phj_pkg::IDX_W-1:0]     csr_index = '0;
   logic [phj_pkg::REG_W-1:0]     csr_wdata = '0;
   int                            mismatches;
   int                            projections_pending;
   int                            send_idle_pct = 24;
   int                            recv_idle_pct = 76;
   int                            quiet_cycles = 0;

   always #5 clock = ~clock;

   pinhole_project_with_jacobian u_dut (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tvalid, .rsp_tready,
      .csr_wen, .csr_index, .csr_wdata
   );

   phj_projection_checker u_checker (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tvalid, .rsp_tready,
      .csr_wen, .csr_index, .csr_wdata, .mismatches, .projections_pending
   );

   // receiver stalls at random with the current idle rate
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // offer one point and hold it until accepted; valid stays high into the next point
   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and let every outstanding projection come back
   task automatic drain_pipeline;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (projections_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the enable stays up, the caller drops it after the last write
   task automatic write_reg(input logic [phj_pkg::IDX_W-1:0] idx,
                            input logic [phj_pkg::REG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // coordinate with a spread of magnitudes: full random, scaled down, or an extreme
   function automatic logic [31:0] random_coord;
      case ($urandom_range(5))
         0, 1:    return $urandom;
         2, 3:    return $signed($urandom) >>> $urandom_range(31, 8);
         4:       return $urandom >> $urandom_range(31, 1);
         default: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   // depth: mostly positive with a wide magnitude range, sometimes zero or negative
   function automatic logic [31:0] random_depth;
      logic [31:0] d;
      if ($urandom_range(99) < 10)
         return ($urandom_range(3) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
      d = ($urandom & 32'h7fff_ffff) >> $urandom_range(30, 0);
      return (d == 0) ? 32'd1 : d;
   endfunction

   initial begin
      logic [phj_pkg::REG_W-1:0] fx, fy, cx, cy;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default intrinsics, depth and coordinate extremes
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // zero depth
      send_point(32'h0001_0000, 32'hffff_0000, 32'hffff_ffff);  // negative depth
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);  // most negative depth
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);  // tiny depth, saturation
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);  // huge intermediates
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      send_point(32'hffff_ffff, 32'h0000_0001, 32'h0003_0000);  // rounding near zero
      send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000);
      send_point(32'h0280_0000, 32'hfe20_0000, 32'h0000_0100);
      send_point(32'h0010_0000, 32'h0010_0000, 32'h0000_0010);
      send_point(32'hfff0_0000, 32'hfff0_0000, 32'h0100_0000);

      for (int ph = 0; ph < 5; ph++) begin
         drain_pipeline();
         // settings: random, all-max, all-zero, small focal lengths, random
         case (ph)
            1:       begin fx = '1; fy = '1; cx = '1; cy = '1; end
            2:       begin fx = '0; fy = '0; cx = '0; cy = '0; end
            3:       begin fx = RGW'($urandom_range(65535)); fy = RGW'($urandom_range(65535));
                           cx = RGW'($urandom); cy = RGW'($urandom); end
            default: begin fx = RGW'($urandom); fy = RGW'($urandom);
                           cx = RGW'($urandom); cy = RGW'($urandom); end
         endcase
         write_reg(phj_pkg::REG_FOCAL_X, fx);
         write_reg(phj_pkg::REG_FOCAL_Y, fy);
         write_reg(phj_pkg::REG_CENTER_X, cx);
         write_reg(phj_pkg::REG_CENTER_Y, cy);
         csr_wen <= 1'b0;
         // idling: sender light then heavy, finally none at all
         if (ph >= 2 && ph < 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 24;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 160; n++) begin
            if (ph == 1 && n == 80) begin
               // hold off until the pipeline has emptied
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (projections_pending != 0) @(posedge clock);
            end
            send_point(random_coord(), random_coord(), random_depth());
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (projections_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

[sim.f]
hw/rtl/phj_pkg.sv
hw/rtl/phj_pipe.sv
hw/rtl/phj_div_cell.sv
hw/rtl/phj_recip.sv
hw/rtl/phj_mul.sv
hw/rtl/pinhole_project_with_jacobian.sv
hw/rtl/phj_checker.sv
sim/phj_projection_checker.sv
sim/pinhole_project_with_jacobian_test.sv
